[hdl/sma_pkg.sv]
package sma_pkg;

  // fixed geometry of the stores (largest supported matrix is 4x4)
  localparam int IDX_W   = 2;
  localparam int POS_W   = 4;
  localparam int NUM_POS = 16;
  localparam int VEC_LEN = 4;
  localparam int DATA_W  = 32;
  localparam int SUM_W   = 67;

  // request opcodes
  typedef enum logic [3:0] {
    OP_LOAD_OPND = 4'd0,
    OP_LOAD_ACC  = 4'd1,
    OP_ADD       = 4'd2,
    OP_SUB       = 4'd3,
    OP_SCALE     = 4'd4,
    OP_MUL       = 4'd5,
    OP_LOAD_VEC  = 4'd6,
    OP_XFORM     = 4'd7,
    OP_READ      = 4'd8
  } opcode_t;

  // sequencer states
  typedef enum logic [1:0] {
    STATE_IDLE,
    STATE_RUN,
    STATE_DRAIN
  } state_t;

  // operation of the shared arithmetic unit
  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_SUB,
    MODE_MUL
  } mode_t;

  // element tag carried along the arithmetic pipeline
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             fin;
  } tag_t;

  // one term issued to the arithmetic unit
  typedef struct packed {
    logic  valid;
    logic  first;
    logic  last;
    mode_t mode;
    tag_t  tag;
  } issue_t;

endpackage

[hdl/small_matrix_alu.sv]
// small matrix unit: accumulator matrix, operand matrix and vector of Q16.16
// values, DIM x DIM with DIM of 2 to 4.
// input channel s_axis: one request per accepted beat; tuser carries the
// opcode, tdata the element index and the value. loads take effect in the
// accept cycle.
// add, subtract, scale and read issue DIM*DIM terms, transform DIM*DIM terms
// and multiply DIM*DIM*DIM terms, one per cycle while the receiver does not
// stall, to a single shared multiply/add unit with a two-stage pipeline;
// s_axis_tready stays low until the last term of a request has come out of
// the pipeline.
// output channel m_axis: transform gives DIM beats (index = row), read gives
// DIM*DIM beats (index = row-major position); tlast marks the final beat.
// the output register lets the block take the next request while the last
// beat waits; when the receiver stalls, the sequencer and the arithmetic
// pipeline freeze until the beat is taken.
// reset clears all three stores to zero and returns the block to idle.
module small_matrix_alu #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // element_index[3:0], data_value[35:4]
  input  logic [3:0]  s_axis_tuser,   // opcode[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // result_value[31:0], result_index[35:32]
  output logic        m_axis_tlast
);

  localparam logic [sma_pkg::IDX_W-1:0] LAST_IDX = sma_pkg::IDX_W'(DIM - 1);
  localparam logic [sma_pkg::POS_W:0]   NUM_USED = (sma_pkg::POS_W + 1)'(DIM * DIM);

  sma_pkg::state_t                     state;
  sma_pkg::state_t                     state_next;
  sma_pkg::opcode_t                    op;
  sma_pkg::opcode_t                    in_op;
  logic signed [sma_pkg::DATA_W-1:0]   scale;
  logic [sma_pkg::IDX_W-1:0]           row;
  logic [sma_pkg::IDX_W-1:0]           col;
  logic [sma_pkg::IDX_W-1:0]           k;
  logic [sma_pkg::IDX_W-1:0]           kmax;
  logic [sma_pkg::IDX_W-1:0]           cmax;
  logic signed [sma_pkg::DATA_W-1:0]   acc   [sma_pkg::NUM_POS];
  logic signed [sma_pkg::DATA_W-1:0]   opnd  [sma_pkg::NUM_POS];
  logic signed [sma_pkg::DATA_W-1:0]   vec   [sma_pkg::VEC_LEN];
  logic signed [sma_pkg::DATA_W-1:0]   rowbuf[sma_pkg::VEC_LEN];
  logic [sma_pkg::POS_W-1:0]           in_idx;
  logic signed [sma_pkg::DATA_W-1:0]   in_val;
  logic                                accept;
  logic                                starts_run;
  logic                                stall;
  logic                                run_end;
  logic                                dot_op;
  logic                                mat_idx_ok;
  logic [sma_pkg::POS_W-1:0]           addr_a;
  logic [sma_pkg::POS_W-1:0]           addr_b;
  logic signed [sma_pkg::DATA_W-1:0]   opa;
  logic signed [sma_pkg::DATA_W-1:0]   opb;
  sma_pkg::issue_t                     issue;
  logic                                res_valid;
  sma_pkg::tag_t                       res_tag;
  logic signed [sma_pkg::DATA_W-1:0]   res_value;
  logic                                wb;
  logic signed [sma_pkg::DATA_W-1:0]   out_value;
  logic [sma_pkg::POS_W-1:0]           out_index;

  // row-major position of (r, c)
  function automatic logic [sma_pkg::POS_W-1:0] pos(
    input logic [sma_pkg::IDX_W-1:0] r,
    input logic [sma_pkg::IDX_W-1:0] c
  );
    pos = sma_pkg::POS_W'(r * sma_pkg::POS_W'(DIM)) + sma_pkg::POS_W'(c);
  endfunction

  // request fields
  assign in_op      = sma_pkg::opcode_t'(s_axis_tuser[3:0]);
  assign in_idx     = s_axis_tdata[3:0];
  assign in_val     = s_axis_tdata[35:4];
  assign accept     = s_axis_tvalid & s_axis_tready;
  assign stall      = m_axis_tvalid & ~m_axis_tready;
  assign mat_idx_ok = ({1'b0, in_idx} < NUM_USED);

  // opcodes that run the sequencer
  always_comb begin
    unique case (in_op) inside
      sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_SCALE,
      sma_pkg::OP_MUL, sma_pkg::OP_XFORM, sma_pkg::OP_READ: starts_run = 1'b1;
      default:                                              starts_run = 1'b0;
    endcase
  end

  // loop bounds for the current request
  assign dot_op  = (op == sma_pkg::OP_MUL) || (op == sma_pkg::OP_XFORM);
  assign kmax    = dot_op ? LAST_IDX : '0;
  assign cmax    = (op == sma_pkg::OP_XFORM) ? '0 : LAST_IDX;
  assign run_end = (k == kmax) && (col == cmax) && (row == LAST_IDX);
  assign wb      = res_valid & ~stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sma_pkg::STATE_IDLE: begin
        if (accept && starts_run) state_next = sma_pkg::STATE_RUN;
      end
      sma_pkg::STATE_RUN: begin
        if (!stall && run_end) state_next = sma_pkg::STATE_DRAIN;
      end
      sma_pkg::STATE_DRAIN: begin
        if (wb && res_tag.fin) state_next = sma_pkg::STATE_IDLE;
      end
      default: state_next = sma_pkg::STATE_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = (state == sma_pkg::STATE_IDLE);
    issue.valid   = (state == sma_pkg::STATE_RUN) && !stall;
    issue.first   = (k == '0);
    issue.last    = (k == kmax);
    issue.tag.row = row;
    issue.tag.col = col;
    issue.tag.fin = (row == LAST_IDX) && (col == cmax);
    unique case (op)
      sma_pkg::OP_SUB:                   issue.mode = sma_pkg::MODE_SUB;
      sma_pkg::OP_ADD, sma_pkg::OP_READ: issue.mode = sma_pkg::MODE_ADD;
      default:                           issue.mode = sma_pkg::MODE_MUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sma_pkg::STATE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      k   <= '0;
    end else if (accept) begin
      row   <= '0;
      col   <= '0;
      k     <= '0;
      op    <= in_op;
      scale <= in_val;
    end else if (issue.valid) begin
      if (k != kmax) begin
        k <= k + 1'b1;
      end else begin
        k <= '0;
        if (col != cmax) begin
          col <= col + 1'b1;
        end else begin
          col <= '0;
          row <= row + 1'b1;
        end
      end
    end
  end

  // operand selection for the shared unit
  assign addr_a = pos(row, dot_op ? k : col);
  assign addr_b = (op == sma_pkg::OP_MUL) ? pos(k, col) : pos(row, col);
  assign opa    = acc[addr_a];

  always_comb begin
    case (op)
      sma_pkg::OP_SCALE: opb = scale;
      sma_pkg::OP_XFORM: opb = vec[k];
      sma_pkg::OP_READ:  opb = '0;
      default:           opb = opnd[addr_b];
    endcase
  end

  sma_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .en        (!stall),
    .issue     (issue),
    .a         (opa),
    .b         (opb),
    .res_valid (res_valid),
    .res_tag   (res_tag),
    .res_value (res_value)
  );

  // accumulator store: loads, element-wise results, product rows
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sma_pkg::NUM_POS; i++) acc[i] <= '0;
    end else if (accept) begin
      if (in_op == sma_pkg::OP_LOAD_ACC && mat_idx_ok) begin
        acc[in_idx] <= in_val;
      end
    end else if (wb) begin
      case (op)
        sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_SCALE: begin
          acc[pos(res_tag.row, res_tag.col)] <= res_value;
        end
        sma_pkg::OP_MUL: begin
          if (res_tag.col == LAST_IDX) begin
            for (int j = 0; j < DIM; j++) begin
              acc[pos(res_tag.row, sma_pkg::IDX_W'(j))] <=
                (j == DIM - 1) ? res_value : rowbuf[j];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // product row buffer
  always_ff @(posedge clk) begin
    if (wb && op == sma_pkg::OP_MUL && res_tag.col != LAST_IDX) begin
      rowbuf[res_tag.col] <= res_value;
    end
  end

  // operand and vector stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sma_pkg::NUM_POS; i++) opnd[i] <= '0;
      for (int i = 0; i < sma_pkg::VEC_LEN; i++) vec[i] <= '0;
    end else if (accept) begin
      if (in_op == sma_pkg::OP_LOAD_OPND && mat_idx_ok) begin
        opnd[in_idx] <= in_val;
      end
      if (in_op == sma_pkg::OP_LOAD_VEC && in_idx < sma_pkg::POS_W'(DIM)) begin
        vec[in_idx[sma_pkg::IDX_W-1:0]] <= in_val;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (wb && (op == sma_pkg::OP_XFORM || op == sma_pkg::OP_READ)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb && (op == sma_pkg::OP_XFORM || op == sma_pkg::OP_READ)) begin
      out_value    <= res_value;
      out_index    <= (op == sma_pkg::OP_XFORM) ? sma_pkg::POS_W'(res_tag.row)
                                                : pos(res_tag.row, res_tag.col);
      m_axis_tlast <= res_tag.fin;
    end
  end

  assign m_axis_tdata = {4'b0000, out_index, out_value};

endmodule

[hdl/sma_mac.sv]
module sma_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  sma_pkg::issue_t                    issue,
  input  logic signed [sma_pkg::DATA_W-1:0]  a,
  input  logic signed [sma_pkg::DATA_W-1:0]  b,
  output logic                               res_valid,
  output sma_pkg::tag_t                      res_tag,
  output logic signed [sma_pkg::DATA_W-1:0]  res_value
);

  localparam logic signed [sma_pkg::SUM_W-1:0] SAT_MAX = 67'sd2147483647;
  localparam logic signed [sma_pkg::SUM_W-1:0] SAT_MIN = -67'sd2147483648;

  logic signed [63:0]               prod;
  logic signed [63:0]               term_next;
  logic signed [63:0]               term;
  logic                             s1_valid;
  logic                             s1_first;
  logic                             s1_last;
  sma_pkg::tag_t                    s1_tag;
  logic signed [sma_pkg::SUM_W-1:0] sum;
  logic signed [sma_pkg::SUM_W-1:0] sum_next;

  // full-width signed product
  assign prod = a * b;

  // term: truncated product, sum or difference
  always_comb begin
    case (issue.mode)
      sma_pkg::MODE_MUL: term_next = prod >>> FRAC_BITS;
      sma_pkg::MODE_SUB: term_next = 64'(a) - 64'(b);
      default:           term_next = 64'(a) + 64'(b);
    endcase
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= issue.valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (en) begin
      term     <= term_next;
      s1_first <= issue.first;
      s1_last  <= issue.last;
      s1_tag   <= issue.tag;
    end
  end

  // exact running sum of terms
  assign sum_next = s1_first ? sma_pkg::SUM_W'(term) : sum + sma_pkg::SUM_W'(term);

  // stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= s1_valid & s1_last;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      sum     <= sum_next;
      res_tag <= s1_tag;
    end
  end

  // saturate to 32 bits
  always_comb begin
    if (sum > SAT_MAX) begin
      res_value = sma_pkg::DATA_W'(SAT_MAX);
    end else if (sum < SAT_MIN) begin
      res_value = sma_pkg::DATA_W'(SAT_MIN);
    end else begin
      res_value = sma_pkg::DATA_W'(sum);
    end
  end

endmodule
